@@ sv/wrn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wrn_pkg;

    // Character codes that the normalizer treats specially
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Spaces kept after a tab, and after the first space of a run after a line feed or elsewhere
    localparam logic [1:0] SPACES_AFTER_TAB = 2'd3;
    localparam logic [1:0] SPACES_AFTER_LF  = 2'd3;
    localparam logic [1:0] SPACES_DEFAULT   = 2'd1;

    // Line feed count at which the second line feed of a break run is emitted
    localparam logic [1:0] LF_COUNT_MAX = 2'd3;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Width of the saturating output length
    localparam int LENGTH_W = 32;

    // Byte classes worked out by the front
    typedef enum logic [2:0] {
        CLS_NUL,
        CLS_TAB,
        CLS_SPACE,
        CLS_CR,
        CLS_LF,
        CLS_OTHER
    } char_class_t;

    // Kind of whitespace run currently open
    typedef enum logic [1:0] {
        RUN_NONE,
        RUN_SPACES,
        RUN_BREAKS
    } run_kind_t;

    // One classified byte waiting in the queue
    typedef struct packed {
        char_class_t cls;
        logic [7:0]  raw_byte;
        logic        end_of_text;
    } queue_entry_t;

    // Handshake between the queue and the back
    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_head_t;

endpackage

`default_nettype wire

@@ sv/wrn_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Raw text channel
interface wrn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

// Normalized result channel
interface wrn_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        final_result;
    logic [31:0] out_length;

    modport source (output valid, output out_byte, output byte_valid,
                    output final_result, output out_length, input ready);
    modport sink (input valid, input out_byte, input byte_valid,
                  input final_result, input out_length, output ready);
endinterface

`default_nettype wire

@@ sv/wrn_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wrn_front
    import wrn_pkg::*;
(
    wrn_in_if.sink       text,
    input  logic         queue_full,
    output logic         push,
    output queue_entry_t push_entry
);

    char_class_t cls;

    // Sort the incoming byte into its class
    always_comb
    begin
        case (text.in_byte)
            CH_NUL:   cls = CLS_NUL;
            CH_TAB:   cls = CLS_TAB;
            CH_SPACE: cls = CLS_SPACE;
            CH_CR:    cls = CLS_CR;
            CH_LF:    cls = CLS_LF;
            default:  cls = CLS_OTHER;
        endcase
    end

    // A transfer is taken whenever the queue has room
    assign text.ready = !queue_full;
    assign push       = text.valid && !queue_full;

    always_comb
    begin
        push_entry.cls         = cls;
        push_entry.raw_byte    = text.in_byte;
        push_entry.end_of_text = text.end_of_text;
    end

endmodule

`default_nettype wire

@@ sv/wrn_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wrn_queue
    import wrn_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output queue_head_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    queue_entry_t     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_COUNT);
    assign head.valid = (count_reg != '0);
    assign head.entry = slots_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // The fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue fill count beyond depth");

    // Pushing into a full queue or popping an empty one would corrupt order
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !head.valid))
        else $error("queue overrun or underrun");

endmodule

`default_nettype wire

@@ sv/wrn_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wrn_back
    import wrn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        pop,
    wrn_out_if.source   result
);

    // Run state
    run_kind_t             run_kind_reg, run_kind_next;
    logic [1:0]            spaces_allowed_reg, spaces_allowed_next;
    logic [1:0]            lf_count_reg, lf_count_next;
    logic                  prev_lf_reg, prev_lf_next;
    logic [LENGTH_W-1:0]   emitted_reg, emitted_next;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  byte_valid_reg, byte_valid_next;
    logic                  final_reg, final_next;
    logic [LENGTH_W-1:0]   length_reg, length_next;

    // Decoded action for the byte at the head of the queue
    logic                  emit;
    logic [7:0]            emit_byte;
    logic [1:0]            lf_count_inc;
    logic [LENGTH_W-1:0]   count_after;

    // Take the next entry when the result register is free or being drained
    assign pop = head.valid && (!out_valid_reg || result.ready);

    assign lf_count_inc = lf_count_reg + 1'b1;

    // Next run state
    always_comb
    begin
        run_kind_next       = run_kind_reg;
        spaces_allowed_next = spaces_allowed_reg;
        lf_count_next       = lf_count_reg;
        case (head.entry.cls)
            CLS_NUL:
            begin
                run_kind_next = RUN_NONE;
            end
            CLS_TAB:
            begin
                run_kind_next       = RUN_SPACES;
                spaces_allowed_next = SPACES_AFTER_TAB;
            end
            CLS_SPACE:
            begin
                if (run_kind_reg == RUN_SPACES)
                begin
                    if (spaces_allowed_reg != 2'd0)
                    begin
                        spaces_allowed_next = spaces_allowed_reg - 1'b1;
                    end
                end
                else
                begin
                    run_kind_next       = RUN_SPACES;
                    spaces_allowed_next = prev_lf_reg ? SPACES_AFTER_LF : SPACES_DEFAULT;
                end
            end
            CLS_CR, CLS_LF:
            begin
                if (run_kind_reg == RUN_BREAKS)
                begin
                    if (head.entry.cls == CLS_LF && lf_count_reg != LF_COUNT_MAX)
                    begin
                        lf_count_next = lf_count_inc;
                    end
                end
                else
                begin
                    run_kind_next = RUN_BREAKS;
                    lf_count_next = (head.entry.cls == CLS_LF) ? 2'd1 : 2'd0;
                end
            end
            CLS_OTHER:
            begin
                run_kind_next = RUN_NONE;
            end
            default:
            begin
                run_kind_next = RUN_NONE;
            end
        endcase
    end

    // Emitted byte for the current entry
    always_comb
    begin
        emit      = 1'b0;
        emit_byte = CH_NUL;
        case (head.entry.cls)
            CLS_NUL:
            begin
                emit = 1'b0;
            end
            CLS_TAB:
            begin
                emit      = 1'b1;
                emit_byte = CH_SPACE;
            end
            CLS_SPACE:
            begin
                emit      = (run_kind_reg != RUN_SPACES) || (spaces_allowed_reg != 2'd0);
                emit_byte = CH_SPACE;
            end
            CLS_CR, CLS_LF:
            begin
                emit_byte = CH_LF;
                if (run_kind_reg != RUN_BREAKS)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    emit = (head.entry.cls == CLS_LF) && (lf_count_reg != LF_COUNT_MAX)
                        && (lf_count_inc == LF_COUNT_MAX);
                end
            end
            CLS_OTHER:
            begin
                emit      = 1'b1;
                emit_byte = head.entry.raw_byte;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Saturating emitted byte count
    assign count_after = (emit && emitted_reg != '1) ? emitted_reg + 1'b1 : emitted_reg;

    // Commit state and load the result register
    always_comb
    begin
        prev_lf_next    = prev_lf_reg;
        emitted_next    = emitted_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        final_next      = final_reg;
        length_next     = length_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            prev_lf_next    = (head.entry.cls == CLS_LF);
            emitted_next    = count_after;
            out_valid_next  = emit || head.entry.end_of_text;
            out_byte_next   = emit ? emit_byte : CH_NUL;
            byte_valid_next = emit;
            final_next      = head.entry.end_of_text;
            length_next     = count_after;
            // The end of a text returns the run state to its starting point
            if (head.entry.end_of_text)
            begin
                prev_lf_next = 1'b0;
                emitted_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_kind_reg       <= RUN_NONE;
            spaces_allowed_reg <= 2'd0;
            lf_count_reg       <= 2'd0;
            prev_lf_reg        <= 1'b0;
            emitted_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (head.entry.end_of_text)
                begin
                    run_kind_reg       <= RUN_NONE;
                    spaces_allowed_reg <= 2'd0;
                    lf_count_reg       <= 2'd0;
                end
                else
                begin
                    run_kind_reg       <= run_kind_next;
                    spaces_allowed_reg <= spaces_allowed_next;
                    lf_count_reg       <= lf_count_next;
                end
            end
            prev_lf_reg   <= prev_lf_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        final_reg      <= final_next;
        length_reg     <= length_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.out_byte     = out_byte_reg;
    assign result.byte_valid   = byte_valid_reg;
    assign result.final_result = final_reg;
    assign result.out_length   = length_reg;

    // A result without a byte only ever closes a text
    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.byte_valid |-> result.final_result)
        else $error("result without byte that is not final");

    // NUL is never emitted
    a_no_nul_out: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.byte_valid |-> result.out_byte != CH_NUL)
        else $error("NUL byte emitted");

    // Taking the last byte of a text clears the run state
    a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.entry.end_of_text |=> emitted_reg == '0 && run_kind_reg == RUN_NONE
            && !prev_lf_reg)
        else $error("state not cleared after end of text");

    // A held result stays in place while the consumer stalls
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(length_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

@@ sv/whitespace_run_normalizer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Role   | Payload
// ---------+--------+---------------------------------------------------
// text     | sink   | in_byte[7:0], end_of_text
// result   | source | out_byte[7:0], byte_valid, final_result, out_length[31:0]
//
// One byte is taken per cycle while the queue has room, classified into the queue,
// and its result, if any, goes through the run update into the result register.
// A byte that produces nothing leaves no result.
// Reset clears the run state, the queue and the result valid flag; no clearing pass.
// A stall on result fills the queue, after which text is held off; text stalls
// leave the back draining on its own.
module whitespace_run_normalizer_top
    import wrn_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    wrn_in_if.sink     text,
    wrn_out_if.source  result
);

    logic         queue_full;
    logic         push;
    queue_entry_t push_entry;
    logic         pop;
    queue_head_t  head;

    // Front: classify and enqueue
    wrn_front u_front (
        .text       (text),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue between front and back
    wrn_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head)
    );

    // Back: run tracking and result register
    wrn_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire

@@ sim/whitespace_run_normalizer_top_test.sv @@
`timescale 1ns / 1ps

module whitespace_run_normalizer_top_test;
    import wrn_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam longint TIMEOUT_NS = 5_000_000;

    // Opening text: kept spaces, a tab inside a space run, spaces after a line
    // feed, a break run with carriage returns and surplus line feeds, a NUL
    // breaking the line feed context, and a final byte that emits nothing.
    localparam bit [7:0] DIRECTED_BYTES [25] = '{
        8'h41, CH_SPACE, CH_SPACE, CH_SPACE, CH_TAB,
        CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE, CH_LF,
        CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE,
        CH_CR, CH_LF, CH_CR, CH_LF, CH_LF,
        CH_LF, CH_NUL, CH_SPACE, 8'hFF, CH_NUL
    };
    localparam bit DIRECTED_LAST [25] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 1, 1
    };

    // Whitespace and control bytes used for noise fragments.
    localparam bit [7:0] SPECIAL_BYTES [5] = '{CH_NUL, CH_TAB, CH_LF, CH_CR, CH_SPACE};

    typedef struct {
        bit [7:0]  out_byte;
        bit        byte_valid;
        bit        final_result;
        bit [31:0] out_length;
    } norm_result_t;

    // Tracks the run state of the current text and holds the results still owed.
    class normalizer_scoreboard;
        run_kind_t    run;
        bit [1:0]     spaces_left;
        bit [1:0]     lf_count;
        bit           after_lf;
        bit [31:0]    emitted;
        norm_result_t awaited[$];
        int           errors;

        function new();
            clear_text();
            errors = 0;
        endfunction

        function void clear_text();
            run = RUN_NONE;
            spaces_left = 2'd0;
            lf_count = 2'd0;
            after_lf = 1'b0;
            emitted = 32'd0;
        endfunction

        // Notes an accepted byte; returns 1 when it owes a result.
        function bit note_text(bit [7:0] b, bit eot);
            bit           emit;
            bit [7:0]     ob;
            norm_result_t r;
            emit = 1'b0;
            ob = CH_NUL;
            if (b == CH_NUL)
            begin
                run = RUN_NONE;
            end
            else if (b == CH_TAB)
            begin
                emit = 1'b1;
                ob = CH_SPACE;
                run = RUN_SPACES;
                spaces_left = SPACES_AFTER_TAB;
            end
            else if (b == CH_SPACE)
            begin
                if (run == RUN_SPACES)
                begin
                    if (spaces_left != 2'd0)
                    begin
                        emit = 1'b1;
                        ob = CH_SPACE;
                        spaces_left--;
                    end
                end
                else
                begin
                    emit = 1'b1;
                    ob = CH_SPACE;
                    run = RUN_SPACES;
                    spaces_left = after_lf ? SPACES_AFTER_LF : SPACES_DEFAULT;
                end
            end
            else if (b == CH_CR || b == CH_LF)
            begin
                if (run == RUN_BREAKS)
                begin
                    // Carriage returns stay in the run but are not counted.
                    if (b == CH_LF && lf_count < LF_COUNT_MAX)
                    begin
                        lf_count++;
                        if (lf_count == LF_COUNT_MAX)
                        begin
                            emit = 1'b1;
                            ob = CH_LF;
                        end
                    end
                end
                else
                begin
                    emit = 1'b1;
                    ob = CH_LF;
                    run = RUN_BREAKS;
                    lf_count = (b == CH_LF) ? 2'd1 : 2'd0;
                end
            end
            else
            begin
                emit = 1'b1;
                ob = b;
                run = RUN_NONE;
            end

            after_lf = (b == CH_LF);
            if (emit && emitted != 32'hFFFF_FFFF)
                emitted++;

            if (emit || eot)
            begin
                r.out_byte = ob;
                r.byte_valid = emit;
                r.final_result = eot;
                r.out_length = emitted;
                awaited.push_back(r);
            end
            if (eot)
                clear_text();
            return emit || eot;
        endfunction

        // Compares a received result with the oldest one owed.
        function void check_result(norm_result_t got);
            norm_result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result byte %h valid %b final %b length %0d",
                         $time, got.out_byte, got.byte_valid, got.final_result,
                         got.out_length);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.out_byte != want.out_byte)
            begin
                $display("%0t: out_byte expected %h, got %h", $time, want.out_byte, got.out_byte);
                errors++;
            end
            if (got.byte_valid != want.byte_valid)
            begin
                $display("%0t: byte_valid expected %b, got %b", $time,
                         want.byte_valid, got.byte_valid);
                errors++;
            end
            if (got.final_result != want.final_result)
            begin
                $display("%0t: final_result expected %b, got %b", $time,
                         want.final_result, got.final_result);
                errors++;
            end
            if (got.out_length != want.out_length)
            begin
                $display("%0t: out_length expected %0d, got %0d", $time,
                         want.out_length, got.out_length);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    wrn_in_if  text();
    wrn_out_if result();

    normalizer_scoreboard sb;
    bit [7:0] text_bytes[$];
    int       items_sent;
    int       sender_calm;
    int       receiver_calm;

    whitespace_run_normalizer_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .result (result)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random waits, broken by occasional stretches with none at all.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // Presents one byte and holds it until the transfer.
    task automatic send_text_byte(input bit [7:0] b, input bit eot);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0)
        begin
            text.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text.valid <= 1'b1;
        text.in_byte <= b;
        text.end_of_text <= eot;
        do @(posedge clk); while (!text.ready);
        void'(sb.note_text(b, eot));
        items_sent++;
    endtask

    // Builds one text from fragments, mostly well-formed runs with random content.
    task automatic compose_text();
        int frags;
        text_bytes.delete();
        frags = $urandom_range(1, 12);
        repeat (frags)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    repeat ($urandom_range(1, 4))
                        text_bytes.push_back(8'($urandom_range(0, 255)));
                2, 3:
                    repeat ($urandom_range(1, 6))
                        text_bytes.push_back(CH_SPACE);
                4:
                begin
                    text_bytes.push_back(CH_TAB);
                    repeat ($urandom_range(0, 5))
                        text_bytes.push_back(CH_SPACE);
                end
                5, 6:
                    repeat ($urandom_range(1, 6))
                        text_bytes.push_back(($urandom_range(0, 2) == 0) ? CH_CR : CH_LF);
                7:
                begin
                    // Line feed, sometimes followed by a carriage return, then spaces.
                    text_bytes.push_back(CH_LF);
                    if ($urandom_range(0, 3) == 0)
                        text_bytes.push_back(CH_CR);
                    repeat ($urandom_range(1, 6))
                        text_bytes.push_back(CH_SPACE);
                end
                8:
                    text_bytes.push_back(CH_NUL);
                default:
                    repeat ($urandom_range(1, 3))
                        text_bytes.push_back(SPECIAL_BYTES[$urandom_range(0, 4)]);
            endcase
        end
    endtask

    // Stimulus and end of run.
    initial
    begin
        rst_n = 1'b0;
        text.valid = 1'b0;
        text.in_byte = 8'h00;
        text.end_of_text = 1'b0;
        result.ready = 1'b0;
        sb = new();
        items_sent = 0;
        sender_calm = 0;
        receiver_calm = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_BYTES[i])
            send_text_byte(DIRECTED_BYTES[i], DIRECTED_LAST[i]);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            compose_text();
            foreach (text_bytes[i])
                send_text_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
        text.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("whitespace_run_normalizer_top_test OK");
        else
            $display("whitespace_run_normalizer_top_test NOT OK");
        $finish;
    end

    // Result side: random stalls, then take and check each transfer.
    initial
    begin
        int           stall;
        norm_result_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(receiver_calm);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (!result.valid);
            got.out_byte = result.out_byte;
            got.byte_valid = result.byte_valid;
            got.final_result = result.final_result;
            got.out_length = result.out_length;
            sb.check_result(got);
        end
    end

    // Guard against a hang.
    initial
    begin
        #(TIMEOUT_NS);
        $display("whitespace_run_normalizer_top_test NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
sv/wrn_pkg.sv
sv/wrn_if.sv
sv/wrn_front.sv
sv/wrn_queue.sv
sv/wrn_back.sv
sv/whitespace_run_normalizer_top.sv
sim/whitespace_run_normalizer_top_test.sv
